>>> hw/rtl/lrgs_pkg.sv
// Shared constants and types for the life rule grid stencil block.
`default_nettype none

package lrgs_pkg;

  localparam int DEF_MAX_COLS = 1024;
  localparam int DEF_MAX_ROWS = 1024;
  localparam int DIM_RESET    = 64;

  localparam int CFG_W     = 11;
  localparam int CFG_IDX_W = 1;
  localparam int POS_W     = 10;

  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLS = 1'b1;

  localparam logic OP_CELL = 1'b0;

  // Which sides of the 3x3 window lie inside the grid
  typedef struct packed {
    logic left;
    logic right;
    logic top;
    logic bottom;
  } edge_mask_t;

endpackage

`default_nettype wire

>>> hw/rtl/lrgs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module lrgs_ram #(
  parameter int WIDTH = 1,
  parameter int DEPTH = 2,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic             clk,
  input  wire logic             we,
  input  wire logic [AW-1:0]    waddr,
  input  wire logic [WIDTH-1:0] wdata,
  input  wire logic             re,
  input  wire logic [AW-1:0]    raddr,
  output logic      [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

>>> hw/rtl/lrgs_window.sv
// 3x3 neighborhood window and the birth-on-3 / survive-on-2-or-3 rule.
`default_nettype none

module lrgs_window (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                shift_en,
  input  wire logic [2:0]          col_in,
  input  wire lrgs_pkg::edge_mask_t mask,
  output logic                     next_cell
);
  import lrgs_pkg::*;

  localparam logic [3:0] BIRTH_COUNT   = 4'd3;
  localparam logic [3:0] SURVIVE_COUNT = 4'd2;

  // Column bits: [2] upper row, [1] middle row, [0] lower row
  logic [2:0] mid_col_r, mid_col_nxt;
  logic [2:0] right_col_r, right_col_nxt;
  logic [2:0] row_keep;
  logic [2:0] left_m, ctr_m, right_m;
  logic [3:0] nbr_cnt;

  always_comb begin
    mid_col_nxt   = mid_col_r;
    right_col_nxt = right_col_r;
    if (shift_en) begin
      mid_col_nxt   = right_col_r;
      right_col_nxt = col_in;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mid_col_r   <= '0;
      right_col_r <= '0;
    end else begin
      mid_col_r   <= mid_col_nxt;
      right_col_r <= right_col_nxt;
    end
  end

  // Left and center come from the stored columns, right is the column being read in
  always_comb begin
    row_keep = {mask.top, 1'b1, mask.bottom};
    left_m   = mid_col_r & row_keep & {3{mask.left}};
    ctr_m    = right_col_r & row_keep;
    right_m  = col_in & row_keep & {3{mask.right}};
    nbr_cnt  = 4'($countones({left_m, right_m, ctr_m[2], ctr_m[0]}));
    next_cell = (nbr_cnt == BIRTH_COUNT) || (ctr_m[1] && (nbr_cnt == SURVIVE_COUNT));
  end

endmodule

`default_nettype wire

>>> hw/rtl/life_rule_grid_stencil_core.sv
// Top level of the Game of Life raster stencil: counters, line store, output register.
//
// Usage: cells of one generation enter on the input channel (in_valid/in_stall)
// in raster order, in_op = 0 for a grid cell and 1 for a flush tick. Each
// result word on the output channel (out_valid/out_stall) carries the next
// generation of one cell with its row, column and a last-of-frame flag.
// Results lag the input stream by grid_cols+1 words; after the last cell send
// grid_cols+1 flush ticks to push out the rest of the frame.
// Throughput: one word per cycle unless the receiver stalls. A word sits in the
// input register while the line store (one RAM, one read and one write port) is
// read, and is then resolved into the output register that drives out_valid.
// Reset clears all counters and both registers' valid flags; grid_rows and
// grid_cols go to 64. A write on the cfg port restarts the frame.
// When the receiver stalls, the output word holds and the input register
// fills; in_stall rises only while both registers are full.
// Early flush ticks are taken and dropped.
`default_nettype none

module life_rule_grid_stencil_core #(
  parameter int MAX_COLS = lrgs_pkg::DEF_MAX_COLS,
  parameter int MAX_ROWS = lrgs_pkg::DEF_MAX_ROWS
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic                           in_op,
  input  wire logic                           in_cell_in,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic                                out_next_cell,
  output logic      [lrgs_pkg::POS_W-1:0]     out_row,
  output logic      [lrgs_pkg::POS_W-1:0]     out_col,
  output logic                                out_frame_last,
  input  wire logic                           cfg_we,
  input  wire logic [lrgs_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [lrgs_pkg::CFG_W-1:0]     cfg_wdata
);
  import lrgs_pkg::*;

  localparam int RW = $clog2(MAX_ROWS + 1);
  localparam int CW = $clog2(MAX_COLS + 1);
  localparam int AW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int RST_ROWS = (DIM_RESET > MAX_ROWS) ? MAX_ROWS : DIM_RESET;
  localparam int RST_COLS = (DIM_RESET > MAX_COLS) ? MAX_COLS : DIM_RESET;

  // Grid size and position counters
  logic [RW-1:0] rows_r, rows_nxt;
  logic [CW-1:0] cols_r, cols_nxt;
  logic [RW-1:0] in_row_r, in_row_nxt;
  logic [CW-1:0] in_col_r, in_col_nxt;
  logic [RW-1:0] emit_row_r, emit_row_nxt;
  logic [CW-1:0] emit_col_r, emit_col_nxt;

  // Input register
  logic          s1_valid_r, s1_valid_nxt;
  logic          s1_is_cell_r;
  logic          s1_bit_r;
  logic          s1_emit_r;
  logic [RW-1:0] s1_row_r;
  logic [CW-1:0] s1_col_r;
  logic          s1_last_r;
  edge_mask_t    s1_mask_r;
  logic [AW-1:0] s1_addr_r;
  logic          s1_fwd_r;
  logic [1:0]    s1_fwd_data_r;

  // Output register
  logic             out_valid_r, out_valid_nxt;
  logic             out_cell_r;
  logic [POS_W-1:0] out_row_r;
  logic [POS_W-1:0] out_col_r;
  logic             out_last_r;

  logic          in_acc, proc, is_cell, in_flush_phase, active, restart_pre, emit;
  logic [RW-1:0] cur_row, cur_er;
  logic [CW-1:0] cur_col, cur_ec;
  logic [RW-1:0] rows_m1;
  logic [CW-1:0] cols_m1;
  edge_mask_t    cur_mask;
  logic [AW-1:0] rd_addr;
  logic [1:0]    ram_rdata, line_rd, line_wr;
  logic          fwd;
  logic [RW-1:0] rows_cfg;
  logic [CW-1:0] cols_cfg;
  logic [2:0]    win_col;
  logic          win_next;

  assign proc     = s1_valid_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_valid_r && !proc;
  assign in_acc   = in_valid && !in_stall;

  assign rows_m1 = rows_r - RW'(1);
  assign cols_m1 = cols_r - CW'(1);

  // Clamp written grid sizes into 1..max
  always_comb begin
    if (cfg_wdata == '0) begin
      rows_cfg = RW'(1);
      cols_cfg = CW'(1);
    end else begin
      rows_cfg = (32'(cfg_wdata) > MAX_ROWS) ? RW'(MAX_ROWS) : RW'(cfg_wdata);
      cols_cfg = (32'(cfg_wdata) > MAX_COLS) ? CW'(MAX_COLS) : CW'(cfg_wdata);
    end
  end

  always_comb begin
    is_cell        = (in_op == OP_CELL);
    in_flush_phase = (in_row_r >= rows_r);
    active         = is_cell || in_flush_phase;
    // A cell arriving during the flush phase starts a new frame
    restart_pre    = is_cell && in_flush_phase;
    cur_row = restart_pre ? '0 : in_row_r;
    cur_col = restart_pre ? '0 : in_col_r;
    cur_er  = restart_pre ? '0 : emit_row_r;
    cur_ec  = restart_pre ? '0 : emit_col_r;

    emit = active && ((cur_row > RW'(1)) || ((cur_row == RW'(1)) && (cur_col != '0)));

    cur_mask.left   = (cur_ec != '0);
    cur_mask.right  = (cur_ec != cols_m1);
    cur_mask.top    = (cur_er != '0);
    cur_mask.bottom = (cur_er != rows_m1);

    rd_addr = cur_col[AW-1:0];
  end

  always_comb begin
    rows_nxt     = rows_r;
    cols_nxt     = cols_r;
    in_row_nxt   = in_row_r;
    in_col_nxt   = in_col_r;
    emit_row_nxt = emit_row_r;
    emit_col_nxt = emit_col_r;
    if (cfg_we) begin
      if (cfg_index == REG_GRID_ROWS) begin
        rows_nxt = rows_cfg;
      end else if (cfg_index == REG_GRID_COLS) begin
        cols_nxt = cols_cfg;
      end
      in_row_nxt   = '0;
      in_col_nxt   = '0;
      emit_row_nxt = '0;
      emit_col_nxt = '0;
    end else if (in_acc && active) begin
      emit_row_nxt = cur_er;
      emit_col_nxt = cur_ec;
      if (emit) begin
        if (cur_ec == cols_m1) begin
          emit_col_nxt = '0;
          emit_row_nxt = cur_er + RW'(1);
        end else begin
          emit_col_nxt = cur_ec + CW'(1);
        end
      end
      if (is_cell) begin
        if (cur_col == cols_m1) begin
          in_col_nxt = '0;
          in_row_nxt = cur_row + RW'(1);
        end else begin
          in_row_nxt = cur_row;
          in_col_nxt = cur_col + CW'(1);
        end
      end else if (in_col_r == cols_r) begin
        // Frame fully flushed: restart
        in_row_nxt   = '0;
        in_col_nxt   = '0;
        emit_row_nxt = '0;
        emit_col_nxt = '0;
      end else begin
        in_col_nxt = in_col_r + CW'(1);
      end
    end
  end

  // Line store: bit 1 upper line, bit 0 middle line
  assign line_rd = s1_fwd_r ? s1_fwd_data_r : ram_rdata;
  assign line_wr = {line_rd[0], s1_bit_r};
  // Same column written by the word ahead on the edge this one is read
  assign fwd     = proc && s1_is_cell_r && (s1_addr_r == rd_addr);

  lrgs_ram #(
    .WIDTH (2),
    .DEPTH (MAX_COLS),
    .AW    (AW)
  ) u_line_ram (
    .clk   (clk),
    .we    (proc && s1_is_cell_r),
    .waddr (s1_addr_r),
    .wdata (line_wr),
    .re    (in_acc && active),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  assign win_col = {line_rd[1], line_rd[0], s1_bit_r};

  lrgs_window u_window (
    .clk       (clk),
    .rst_n     (rst_n),
    .shift_en  (proc),
    .col_in    (win_col),
    .mask      (s1_mask_r),
    .next_cell (win_next)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_acc && active) begin
      s1_valid_nxt = 1'b1;
    end else if (proc) begin
      s1_valid_nxt = 1'b0;
    end

    out_valid_nxt = out_valid_r;
    if (proc) begin
      out_valid_nxt = s1_emit_r;
    end else if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rows_r      <= RW'(RST_ROWS);
      cols_r      <= CW'(RST_COLS);
      in_row_r    <= '0;
      in_col_r    <= '0;
      emit_row_r  <= '0;
      emit_col_r  <= '0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      rows_r      <= rows_nxt;
      cols_r      <= cols_nxt;
      in_row_r    <= in_row_nxt;
      in_col_r    <= in_col_nxt;
      emit_row_r  <= emit_row_nxt;
      emit_col_r  <= emit_col_nxt;
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && active) begin
      s1_is_cell_r  <= is_cell;
      s1_bit_r      <= is_cell && in_cell_in;
      s1_emit_r     <= emit;
      s1_row_r      <= cur_er;
      s1_col_r      <= cur_ec;
      s1_last_r     <= !cur_mask.bottom && !cur_mask.right;
      s1_mask_r     <= cur_mask;
      s1_addr_r     <= rd_addr;
      s1_fwd_r      <= fwd;
      s1_fwd_data_r <= line_wr;
    end
    if (proc) begin
      out_cell_r <= win_next;
      out_row_r  <= POS_W'(s1_row_r);
      out_col_r  <= POS_W'(s1_col_r);
      out_last_r <= s1_last_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_next_cell  = out_cell_r;
  assign out_row        = out_row_r;
  assign out_col        = out_col_r;
  assign out_frame_last = out_last_r;

endmodule

`default_nettype wire

>>> hw/rtl/lrgs_checker.sv
// Port-level checks for the life rule grid stencil core, bound to the top level.
`default_nettype none

module lrgs_checker (
  input wire logic                           clk,
  input wire logic                           rst_n,
  input wire logic                           in_valid,
  input wire logic                           in_stall,
  input wire logic                           in_op,
  input wire logic                           in_cell_in,
  input wire logic                           out_valid,
  input wire logic                           out_stall,
  input wire logic                           out_next_cell,
  input wire logic [lrgs_pkg::POS_W-1:0]     out_row,
  input wire logic [lrgs_pkg::POS_W-1:0]     out_col,
  input wire logic                           out_frame_last,
  input wire logic                           cfg_we,
  input wire logic [lrgs_pkg::CFG_IDX_W-1:0] cfg_index,
  input wire logic [lrgs_pkg::CFG_W-1:0]     cfg_wdata
);

  // Reset leaves no result word pending
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high after reset");

  // A stalled result word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_next_cell) && $stable(out_row)
      && $stable(out_col) && $stable(out_frame_last))
    else $error("stalled result word changed");

  // Input backs up only behind a full, stalled output register
  a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("in_stall without a stalled output word");

endmodule

bind life_rule_grid_stencil_core lrgs_checker u_lrgs_checker (.*);

`default_nettype wire

>>> bench/life_rule_grid_stencil_core_test.sv
// Self-checking bench for the Game of Life raster stencil core, with its own predictor.
`default_nettype none

module life_rule_grid_stencil_core_test;
  timeunit 1ns;
  timeprecision 1ps;

  import lrgs_pkg::*;

  localparam logic OP_FLUSH = 1'b1;

  typedef struct {
    logic op;
    logic cell_bit;
  } feed_word_t;

  typedef struct {
    logic             alive;
    logic [POS_W-1:0] row;
    logic [POS_W-1:0] col;
    logic             last;
  } life_res_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic                 in_op = OP_CELL;
  logic                 in_cell_in = 1'b0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic                 out_next_cell;
  logic [POS_W-1:0]     out_row;
  logic [POS_W-1:0]     out_col;
  logic                 out_frame_last;
  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_GRID_ROWS;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  feed_word_t feed_q[$];
  life_res_t  next_gen_q[$];

  int errors = 0;
  int cells_sent = 0;
  int gap_pct = 0;
  int stall_pct = 0;
  int gap_left = 0;
  int stall_left = 0;
  bit quiet = 1'b0;

  // Predictor state
  int unsigned dim_rows;
  int unsigned dim_cols;
  int unsigned in_r, in_c, em_r, em_c;
  bit          life_line [3][DEF_MAX_COLS];

  life_rule_grid_stencil_core dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_op         (in_op),
    .in_cell_in    (in_cell_in),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_next_cell (out_next_cell),
    .out_row       (out_row),
    .out_col       (out_col),
    .out_frame_last(out_frame_last),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_wdata     (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic void rewind_frame();
    in_r = 0;
    in_c = 0;
    em_r = 0;
    em_c = 0;
  endfunction

  function automatic int unsigned clamp_dim(logic [CFG_W-1:0] v, int unsigned maxv);
    if (v == 0) return 1;
    if (v > maxv) return maxv;
    return 32'(v);
  endfunction

  // Cells outside the grid are dead; the arriving cell comes from the word itself.
  function automatic bit grid_cell(int r, int c, bit have_new, bit nv);
    if (r < 0 || c < 0 || r >= int'(dim_rows) || c >= int'(dim_cols)) return 1'b0;
    if (have_new && r == int'(in_r) && c == int'(in_c)) return nv;
    return life_line[r % 3][c];
  endfunction

  task automatic step_life(input logic op, input logic cell_bit);
    bit          have_new;
    int unsigned pos;
    int          n;
    bit          self_alive;
    life_res_t   res;
    have_new = (op == OP_CELL);
    if (have_new) begin
      if (in_r >= dim_rows) rewind_frame();
      pos = in_r * dim_cols + in_c;
    end else begin
      // drop flush ticks that come before the last cell
      if (in_r < dim_rows) return;
      pos = dim_rows * dim_cols + in_c;
    end
    if (pos >= dim_cols + 1) begin
      n = 0;
      for (int dr = -1; dr <= 1; dr++) begin
        for (int dc = -1; dc <= 1; dc++) begin
          if (dr != 0 || dc != 0)
            n += grid_cell(int'(em_r) + dr, int'(em_c) + dc, have_new, cell_bit);
        end
      end
      self_alive = grid_cell(int'(em_r), int'(em_c), have_new, cell_bit);
      res.alive = self_alive ? (n == 2 || n == 3) : (n == 3);
      res.row = em_r[POS_W-1:0];
      res.col = em_c[POS_W-1:0];
      res.last = (em_r == dim_rows - 1 && em_c == dim_cols - 1);
      next_gen_q.push_back(res);
      em_c++;
      if (em_c >= dim_cols) begin
        em_c = 0;
        em_r++;
      end
    end
    if (have_new) begin
      life_line[in_r % 3][in_c] = cell_bit;
      in_c++;
      if (in_c >= dim_cols) begin
        in_c = 0;
        in_r++;
      end
    end else begin
      in_c++;
      if (in_c > dim_cols) rewind_frame();
    end
  endtask

  task automatic report_mismatch(input string what);
    $display("ERROR @%0t: %s", $time, what);
    errors++;
  endtask

  // Input driver
  always @(posedge clk) begin : feed_proc
    feed_word_t w;
    if (!rst_n) begin
      in_valid <= 1'b0;
      gap_left = 0;
      dim_rows = DIM_RESET;
      dim_cols = DIM_RESET;
      rewind_frame();
    end else begin
      if (in_valid && !in_stall) step_life(in_op, in_cell_in);
      if (in_valid && in_stall) begin
        // hold the word
      end else if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (!quiet && $urandom_range(0, 99) < gap_pct) begin
        gap_left = $urandom_range(0, 7);
        in_valid <= 1'b0;
      end else if (feed_q.size() > 0) begin
        w = feed_q.pop_front();
        in_valid <= 1'b1;
        in_op <= w.op;
        in_cell_in <= w.cell_bit;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result monitor and receiver stall
  always @(posedge clk) begin : result_proc
    life_res_t want;
    if (!rst_n) begin
      out_stall <= 1'b0;
      stall_left = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (next_gen_q.size() == 0) begin
          report_mismatch($sformatf("unexpected result row %0d col %0d", out_row, out_col));
        end else begin
          want = next_gen_q.pop_front();
          if (out_next_cell !== want.alive)
            report_mismatch($sformatf("next_cell %b, want %b at (%0d,%0d)",
                                      out_next_cell, want.alive, want.row, want.col));
          if (out_row !== want.row)
            report_mismatch($sformatf("out_row %0d, want %0d", out_row, want.row));
          if (out_col !== want.col)
            report_mismatch($sformatf("out_col %0d, want %0d", out_col, want.col));
          if (out_frame_last !== want.last)
            report_mismatch($sformatf("frame_last %b, want %b at (%0d,%0d)",
                                      out_frame_last, want.last, want.row, want.col));
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        out_stall <= 1'b1;
      end else if (!quiet && $urandom_range(0, 99) < stall_pct) begin
        stall_left = $urandom_range(0, 7);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  task automatic push_word(input logic op, input logic cell_bit);
    feed_word_t w;
    w.op = op;
    w.cell_bit = cell_bit;
    feed_q.push_back(w);
    cells_sent++;
  endtask

  // Queue ncells raster cells, with optional early flush ticks, then nflush flush ticks.
  task automatic send_frame(input int density, input int early_pct, input int ncells,
                            input int nflush);
    for (int i = 0; i < ncells; i++) begin
      if ($urandom_range(0, 99) < early_pct) push_word(OP_FLUSH, 1'($urandom));
      push_word(OP_CELL, 1'($urandom_range(0, 99) < density));
    end
    repeat (nflush) push_word(OP_FLUSH, 1'($urandom));
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    if (idx == REG_GRID_ROWS) dim_rows = clamp_dim(val, DEF_MAX_ROWS);
    else dim_cols = clamp_dim(val, DEF_MAX_COLS);
    rewind_frame();
    @(posedge clk);
    cfg_we <= 1'b0;
  endtask

  // Wait for every word to be taken and every result to arrive, then let the pipe settle.
  task automatic drain();
    do @(posedge clk);
    while (feed_q.size() != 0 || in_valid || next_gen_q.size() != 0);
    repeat (8) @(posedge clk);
  endtask

  function automatic logic [CFG_W-1:0] pick_dim();
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return CFG_W'($urandom_range(1, 6));
    if (r < 97) return CFG_W'($urandom_range(7, 24));
    return '0;
  endfunction

  function automatic int pick_pct();
    case ($urandom_range(0, 3))
      0: return 0;
      1: return 3;
      2: return 15;
      default: return 40;
    endcase
  endfunction

  initial begin : stim_proc
    int  mode;
    int  nframes;
    int  kind;
    int  density;
    bit  phase_done;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    gap_pct = 15;
    stall_pct = 15;
    // Reset dimensions: an early flush tick is dropped, then the first rows of a frame
    push_word(OP_FLUSH, 1'b1);
    send_frame(30, 0, 2 * DIM_RESET + 8, 0);
    drain();

    // Blinker on a 3x3 grid with an early flush tick inside the frame
    write_reg(REG_GRID_ROWS, 11'd3);
    write_reg(REG_GRID_COLS, 11'd3);
    for (int i = 0; i < 9; i++) begin
      if (i == 4) push_word(OP_FLUSH, 1'b0);
      push_word(OP_CELL, 1'(i % 3 == 1));
    end
    repeat (5) push_word(OP_FLUSH, 1'b0);
    // Full grid, flush cut short by a cell that opens the next frame
    repeat (9) push_word(OP_CELL, 1'b1);
    repeat (2) push_word(OP_FLUSH, 1'b1);
    send_frame(50, 0, 9, 4);
    drain();

    // Zero acts as one: a lone cell on a 1x1 grid
    write_reg(REG_GRID_ROWS, '0);
    write_reg(REG_GRID_COLS, 11'd1);
    push_word(OP_CELL, 1'b1);
    repeat (2) push_word(OP_FLUSH, 1'b0);
    drain();

    // Widest grid; an oversize value clamps to the maximum, first results pushed out
    write_reg(REG_GRID_COLS, '1);
    send_frame(40, 0, DEF_MAX_COLS, 3);
    drain();

    while (cells_sent < 2000) begin
      quiet = (cells_sent >= 1700);
      gap_pct = pick_pct();
      stall_pct = pick_pct();
      mode = $urandom_range(1, 3);
      if (mode[0]) write_reg(REG_GRID_ROWS, pick_dim());
      if (mode[1]) write_reg(REG_GRID_COLS, pick_dim());
      nframes = $urandom_range(1, 3);
      phase_done = 1'b0;
      for (int f = 0; f < nframes && !phase_done; f++) begin
        kind = $urandom_range(0, 9);
        density = $urandom_range(5, 70);
        if (kind <= 6) begin
          send_frame(density, (kind == 0) ? 10 : 0, dim_rows * dim_cols,
                     dim_cols + 1 + ((kind == 1) ? $urandom_range(1, 3) : 0));
        end else if (kind == 7) begin
          // cut the flush short; the next cell restarts the frame
          send_frame(density, 0, dim_rows * dim_cols, $urandom_range(0, dim_cols));
        end else if (kind == 8) begin
          // abandon the frame midway; the next register write restarts it
          send_frame(density, 0, $urandom_range(1, dim_rows * dim_cols), 0);
          phase_done = 1'b1;
        end else begin
          repeat ($urandom_range(1, 12)) push_word(1'($urandom), 1'($urandom));
          phase_done = 1'b1;
        end
      end
      drain();
    end

    if (errors == 0 && next_gen_q.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin : watchdog_proc
    #10_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule

`default_nettype wire
